### rtl/core/rwv_pkg.sv
// Shared constants, command/status types and width helpers for the rolling window volatility block.
package rwv_pkg;

  localparam int DEF_WINDOW_DEPTH = 64;
  localparam int SAMPLE_W         = 24;
  localparam int COUNT_OUT_W      = 7;
  localparam int VAR_W            = 48;
  localparam int VOL_W            = 32;
  localparam int WL_W             = 7;
  localparam int PPY_W            = 16;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 16;
  localparam int SQRT_W           = 64;
  localparam int SQRT_STEPS       = 32;

  localparam logic [WL_W-1:0]      WL_RESET  = 7'd64;
  localparam logic [PPY_W-1:0]     PPY_RESET = 16'd252;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIODS       = 1'b1;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // count register width: holds 0..depth
  function automatic int cnt_w(input int depth);
    return $clog2(depth + 1);
  endfunction

  // signed window sum width
  function automatic int sum_w(input int depth);
    return SAMPLE_W + $clog2(depth);
  endfunction

  // unsigned square sum width
  function automatic int sq_w(input int depth);
    return 2 * SAMPLE_W - 1 + $clog2(depth);
  endfunction

  // width of n*Q - S*S
  function automatic int num_w(input int depth);
    return cnt_w(depth) + sq_w(depth);
  endfunction

  typedef struct packed {
    logic take;
    logic clear;
    logic rd_old;
    logic drop_sq;
    logic drop_upd;
    logic add_sq;
    logic add_upd;
    logic mul;
    logic div_var_ld;
    logic div_step;
    logic var_cap;
    logic sqrt_ld;
    logic sqrt_step;
    logic mean_ld;
    logic mean_fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic full;
    logic two_plus;
  } sts_t;

endpackage

### rtl/core/rwv_if.sv
// Valid/ready channel interfaces for samples in and statistics out.
interface rwv_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic signed [rwv_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

interface rwv_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 stats_valid;
  logic [rwv_pkg::COUNT_OUT_W-1:0]      sample_count;
  logic signed [rwv_pkg::SAMPLE_W-1:0]  window_mean;
  logic [rwv_pkg::VAR_W-1:0]            window_variance;
  logic [rwv_pkg::VOL_W-1:0]            annual_volatility;

  modport source (output valid, output stats_valid, output sample_count, output window_mean,
                  output window_variance, output annual_volatility, input ready);
  modport sink   (input valid, input stats_valid, input sample_count, input window_mean,
                  input window_variance, input annual_volatility, output ready);
endinterface

### rtl/core/rolling_window_volatility.sv
// Top level of the rolling window volatility block: config registers, sequencer and datapath.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------------
//  in_ch   | in  | valid/ready        | op, sample
//  out_ch  | out | valid/ready        | stats_valid, sample_count, window_mean,
//          |     |                    | window_variance, annual_volatility
//  cfg     | in  | cfg_we, no wait    | cfg_index, cfg_wdata
//
//  One request at a time. A clear goes from the clear check to the output load and
//  back to idle. An add with a full window and two or more held steps through full
//  check, drop, add, multiply, variance divide (NW bits, the width of n*Q - S^2, 60 at
//  depth 64), square root, mean divide (SW bits, the sum width, 30), mean finish and
//  output load; a window not yet full skips the two drop states, and a single held
//  sample skips variance and root. The serial divider (one quotient bit a cycle, used
//  for variance then mean) and the square root (one bit a cycle, 32 steps) run in turn.
//  Reset clears pointer, count and sums; ring contents stay undefined. The finished
//  result sits in an output register while the next request is taken; a stalled sink
//  holds only the next finish, and in_ch.ready is high whenever no request is in flight.
module rolling_window_volatility #(
  parameter int WINDOW_DEPTH = rwv_pkg::DEF_WINDOW_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rwv_in_if.sink                            in_ch,
  rwv_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [rwv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rwv_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // configuration registers
  logic [rwv_pkg::WL_W-1:0]  wl_r;
  logic [rwv_pkg::PPY_W-1:0] ppy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r  <= rwv_pkg::WL_RESET;
      ppy_r <= rwv_pkg::PPY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rwv_pkg::REG_WINDOW_LENGTH: wl_r  <= cfg_wdata[rwv_pkg::WL_W-1:0];
        rwv_pkg::REG_PERIODS:       ppy_r <= cfg_wdata[rwv_pkg::PPY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rwv_pkg::cmd_t cmd;
  rwv_pkg::sts_t sts;

  rwv_ctrl #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  rwv_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_op                 (in_ch.op),
    .in_sample             (in_ch.sample),
    .window_length         (wl_r),
    .ann_periods           (ppy_r),
    .res_stats_valid       (out_ch.stats_valid),
    .res_sample_count      (out_ch.sample_count),
    .res_window_mean       (out_ch.window_mean),
    .res_window_variance   (out_ch.window_variance),
    .res_annual_volatility (out_ch.annual_volatility)
  );

endmodule

### rtl/core/rwv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rwv_ram #(
  parameter int W = 24,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/rwv_ctrl.sv
// Sequencer for one request: window update, serial divide, serial square root, output load.
module rwv_ctrl #(
  parameter int WINDOW_DEPTH = rwv_pkg::DEF_WINDOW_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_ready,
  output logic           out_valid,
  input  rwv_pkg::sts_t  sts,
  output rwv_pkg::cmd_t  cmd
);

  localparam int NW   = rwv_pkg::num_w(WINDOW_DEPTH);
  localparam int SW   = rwv_pkg::sum_w(WINDOW_DEPTH);
  localparam int CNTW = $clog2(NW);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CLR  = 4'd1;
  localparam logic [3:0] ST_CHK  = 4'd2;
  localparam logic [3:0] ST_DRP1 = 4'd3;
  localparam logic [3:0] ST_DRP2 = 4'd4;
  localparam logic [3:0] ST_ADD1 = 4'd5;
  localparam logic [3:0] ST_ADD2 = 4'd6;
  localparam logic [3:0] ST_MUL  = 4'd7;
  localparam logic [3:0] ST_SUB  = 4'd8;
  localparam logic [3:0] ST_DVV  = 4'd9;
  localparam logic [3:0] ST_PRD  = 4'd10;
  localparam logic [3:0] ST_SQS  = 4'd11;
  localparam logic [3:0] ST_MNI  = 4'd12;
  localparam logic [3:0] ST_DVM  = 4'd13;
  localparam logic [3:0] ST_MNF  = 4'd14;
  localparam logic [3:0] ST_OUT  = 4'd15;

  logic [3:0]      state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_CLR;
        end
      end
      ST_CLR: begin
        if (sts.is_clear) begin
          cmd.clear = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (sts.full) begin
          cmd.rd_old = 1'b1;
          state_nxt  = ST_DRP1;
        end else begin
          state_nxt = ST_ADD1;
        end
      end
      ST_DRP1: begin
        cmd.drop_sq = 1'b1;
        state_nxt   = ST_DRP2;
      end
      ST_DRP2: begin
        cmd.drop_upd = 1'b1;
        state_nxt    = ST_ADD1;
      end
      ST_ADD1: begin
        cmd.add_sq = 1'b1;
        state_nxt  = ST_ADD2;
      end
      ST_ADD2: begin
        cmd.add_upd = 1'b1;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        if (sts.two_plus) begin
          cmd.div_var_ld = 1'b1;
          cnt_nxt        = CNTW'(NW - 1);
          state_nxt      = ST_DVV;
        end else begin
          state_nxt = ST_MNI;
        end
      end
      ST_DVV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_PRD;
        end
      end
      ST_PRD: begin
        cmd.var_cap = 1'b1;
        cmd.sqrt_ld = 1'b1;
        cnt_nxt     = CNTW'(rwv_pkg::SQRT_STEPS - 1);
        state_nxt   = ST_SQS;
      end
      ST_SQS: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_MNI;
        end
      end
      ST_MNI: begin
        cmd.mean_ld = 1'b1;
        cnt_nxt     = CNTW'(SW - 1);
        state_nxt   = ST_DVM;
      end
      ST_DVM: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_MNF;
        end
      end
      ST_MNF: begin
        cmd.mean_fin = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/core/rwv_dp.sv
// Datapath: ring, exact sums, shared restoring divider, bitwise square root, result registers.
module rwv_dp #(
  parameter int WINDOW_DEPTH = rwv_pkg::DEF_WINDOW_DEPTH
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  rwv_pkg::cmd_t                          cmd,
  output rwv_pkg::sts_t                          sts,
  input  logic                                   in_op,
  input  logic signed [rwv_pkg::SAMPLE_W-1:0]    in_sample,
  input  logic [rwv_pkg::WL_W-1:0]               window_length,
  input  logic [rwv_pkg::PPY_W-1:0]              ann_periods,
  output logic                                   res_stats_valid,
  output logic [rwv_pkg::COUNT_OUT_W-1:0]        res_sample_count,
  output logic signed [rwv_pkg::SAMPLE_W-1:0]    res_window_mean,
  output logic [rwv_pkg::VAR_W-1:0]              res_window_variance,
  output logic [rwv_pkg::VOL_W-1:0]              res_annual_volatility
);

  localparam int XW = rwv_pkg::SAMPLE_W;
  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = rwv_pkg::cnt_w(WINDOW_DEPTH);
  localparam int SW = rwv_pkg::sum_w(WINDOW_DEPTH);
  localparam int QW = rwv_pkg::sq_w(WINDOW_DEPTH);
  localparam int NW = rwv_pkg::num_w(WINDOW_DEPTH);
  localparam int DW = 2 * CW;
  localparam int LW = (CW > rwv_pkg::WL_W) ? CW : rwv_pkg::WL_W;
  localparam int OW = AW + 2;
  localparam int RW = rwv_pkg::SQRT_W;
  localparam int VW = rwv_pkg::VAR_W;

  // control-side state
  logic [AW-1:0]        wp_r;
  logic [CW-1:0]        held_r;
  logic signed [SW-1:0] sum_r;
  logic [QW-1:0]        sq_sum_r;

  // payload registers
  logic                 op_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] old_r;
  logic [QW-1:0]        sq_r;
  logic [NW-1:0]        nq_r;
  logic [2*SW-1:0]      ss_r;
  logic [DW-1:0]        nn_r;
  logic [NW-1:0]        dvd_r;
  logic [DW-1:0]        dvs_r;
  logic [DW-1:0]        rem_r;
  logic [VW-1:0]        quo_r;
  logic [RW-1:0]        v_r, r_r, bit_r;
  logic [VW-1:0]        var_r;
  logic [rwv_pkg::VOL_W-1:0] vol_r;
  logic signed [XW-1:0] mean_r;

  // ring
  logic [XW-1:0] ram_rdata;
  logic [AW-1:0] old_addr;
  logic [OW-1:0] old_sum;

  always_comb begin
    old_sum = OW'(wp_r) + OW'(WINDOW_DEPTH) - OW'(held_r);
    if (old_sum >= OW'(WINDOW_DEPTH)) begin
      old_sum = old_sum - OW'(WINDOW_DEPTH);
    end
    old_addr = old_sum[AW-1:0];
  end

  rwv_ram #(
    .W (XW),
    .D (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.add_sq),
    .waddr (wp_r),
    .wdata (x_r),
    .raddr (old_addr),
    .rdata (ram_rdata)
  );

  // effective window length, clamped to [2, depth]
  logic [LW-1:0] wl_x, len_eff;
  always_comb begin
    wl_x = LW'(window_length);
    if (wl_x < LW'(2)) begin
      len_eff = LW'(2);
    end else if (wl_x > LW'(WINDOW_DEPTH)) begin
      len_eff = LW'(WINDOW_DEPTH);
    end else begin
      len_eff = wl_x;
    end
  end

  assign sts.is_clear = (op_r == rwv_pkg::OP_CLEAR);
  assign sts.full     = (LW'(held_r) >= len_eff);
  assign sts.two_plus = (held_r >= CW'(2));

  // shared squarer for dropped and added samples
  logic signed [XW-1:0]   sq_opnd;
  logic signed [2*XW-1:0] sq_prod;
  assign sq_opnd = cmd.drop_sq ? $signed(ram_rdata) : x_r;
  assign sq_prod = sq_opnd * sq_opnd;

  // |S|
  logic [SW-1:0] mag;
  assign mag = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);

  // one restoring divide step
  logic [DW:0]   rem_sh;
  logic          q_bit;
  logic [DW-1:0] rem_next;
  always_comb begin
    rem_sh = {rem_r, dvd_r[NW-1]};
    q_bit  = (rem_sh >= {1'b0, dvs_r});
    if (q_bit) begin
      rem_next = DW'(rem_sh - {1'b0, dvs_r});
    end else begin
      rem_next = rem_sh[DW-1:0];
    end
  end

  // one square root step
  logic [RW-1:0] sq_trial;
  assign sq_trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      held_r   <= '0;
      sum_r    <= '0;
      sq_sum_r <= '0;
      op_r     <= rwv_pkg::OP_ADD;
    end else begin
      if (cmd.take) begin
        op_r <= in_op;
      end
      if (cmd.clear) begin
        wp_r     <= '0;
        held_r   <= '0;
        sum_r    <= '0;
        sq_sum_r <= '0;
      end
      if (cmd.drop_upd) begin
        sum_r    <= sum_r - SW'(old_r);
        sq_sum_r <= sq_sum_r - sq_r;
        held_r   <= held_r - 1'b1;
      end
      if (cmd.add_upd) begin
        sum_r    <= sum_r + SW'(x_r);
        sq_sum_r <= sq_sum_r + sq_r;
        held_r   <= held_r + 1'b1;
        wp_r     <= (wp_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      x_r <= in_sample;
    end
    if (cmd.drop_sq) begin
      old_r <= $signed(ram_rdata);
    end
    if (cmd.drop_sq || cmd.add_sq) begin
      sq_r <= QW'(unsigned'(sq_prod));
    end
    if (cmd.clear || cmd.add_upd) begin
      var_r  <= '0;
      vol_r  <= '0;
      mean_r <= '0;
    end
    if (cmd.mul) begin
      nq_r <= NW'(held_r) * NW'(sq_sum_r);
      ss_r <= (2*SW)'(mag) * (2*SW)'(mag);
      nn_r <= DW'(held_r) * DW'(held_r - 1'b1);
    end
    if (cmd.div_var_ld) begin
      dvd_r <= nq_r - NW'(ss_r);
      dvs_r <= nn_r;
      rem_r <= '0;
      quo_r <= '0;
    end
    if (cmd.mean_ld) begin
      dvd_r <= NW'(mag) << (NW - SW);
      dvs_r <= DW'(held_r);
      rem_r <= '0;
      quo_r <= '0;
      if (sts.two_plus) begin
        vol_r <= r_r[rwv_pkg::VOL_W-1:0];
      end
    end
    if (cmd.div_step) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_next;
      quo_r <= {quo_r[VW-2:0], q_bit};
    end
    if (cmd.var_cap) begin
      var_r <= quo_r;
    end
    if (cmd.sqrt_ld) begin
      v_r   <= RW'(quo_r) * RW'(ann_periods);
      r_r   <= '0;
      bit_r <= RW'(1) << (RW - 2);
    end
    if (cmd.sqrt_step) begin
      if (v_r >= sq_trial) begin
        v_r <= v_r - sq_trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.mean_fin) begin
      mean_r <= sum_r[SW-1] ? -$signed(quo_r[XW-1:0]) : $signed(quo_r[XW-1:0]);
    end
    if (cmd.out_load) begin
      res_stats_valid       <= sts.two_plus;
      res_sample_count      <= rwv_pkg::COUNT_OUT_W'(held_r);
      res_window_mean       <= mean_r;
      res_window_variance   <= var_r;
      res_annual_volatility <= vol_r;
    end
  end

endmodule

### verif/tb.sv
// Testbench for the rolling window volatility block, checked against an in-bench predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W    = rwv_pkg::SAMPLE_W;
  localparam int COUNT_OUT_W = rwv_pkg::COUNT_OUT_W;
  localparam int VAR_W       = rwv_pkg::VAR_W;
  localparam int VOL_W       = rwv_pkg::VOL_W;
  localparam int WL_W        = rwv_pkg::WL_W;
  localparam int PPY_W       = rwv_pkg::PPY_W;
  localparam int CFG_IDX_W   = rwv_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = rwv_pkg::CFG_DATA_W;
  localparam int DEPTH       = rwv_pkg::DEF_WINDOW_DEPTH;

  typedef struct {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;
  } sample_req_t;

  typedef struct {
    logic                       stats_valid;
    logic [COUNT_OUT_W-1:0]     sample_count;
    logic signed [SAMPLE_W-1:0] window_mean;
    logic [VAR_W-1:0]           window_variance;
    logic [VOL_W-1:0]           annual_volatility;
  } window_stats_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rwv_in_if  in_ch ();
  rwv_out_if out_ch ();

  rolling_window_volatility u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // requests waiting to be offered, and statistics waiting to come back
  sample_req_t   pending_reqs[$];
  window_stats_t expected_stats[$];
  int            fail_count;
  int            added_count;

  // predictor's copy of the block state and registers
  logic signed [SAMPLE_W-1:0] ring_copy[DEPTH];
  int      ring_wr;
  int      ring_held;
  longint  sum_copy;
  longint  sq_sum_copy;
  logic [WL_W-1:0]  wl_copy;
  logic [PPY_W-1:0] ppy_copy;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit [63:0] floor_sqrt(input bit [63:0] v);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Advance the window by one request and queue the statistics it must produce.
  task automatic predict_window(input sample_req_t req);
    window_stats_t st;
    int        eff_len;
    int        oldest;
    longint    x;
    longint    o;
    bit [63:0] n;
    bit [63:0] mag;
    bit [63:0] num;
    bit [63:0] var64;
    bit [63:0] prod;
    st = '{default: '0};
    if (req.op == rwv_pkg::OP_CLEAR) begin
      ring_wr = 0;
      ring_held = 0;
      sum_copy = 0;
      sq_sum_copy = 0;
    end else begin
      x = longint'(req.sample);
      eff_len = int'(wl_copy);
      if (eff_len < 2) eff_len = 2;
      if (eff_len > DEPTH) eff_len = DEPTH;
      // full window (or shortened length): drop the oldest held sample
      if (ring_held >= eff_len) begin
        oldest = (ring_wr + DEPTH - ring_held) % DEPTH;
        o = longint'(ring_copy[oldest]);
        sum_copy -= o;
        sq_sum_copy -= o * o;
        ring_held--;
      end
      ring_copy[ring_wr] = req.sample;
      ring_wr = (ring_wr + 1) % DEPTH;
      ring_held++;
      sum_copy += x;
      sq_sum_copy += x * x;
      n = ring_held;
      st.sample_count = n[COUNT_OUT_W-1:0];
      st.window_mean  = SAMPLE_W'(sum_copy / longint'(n));
      if (n >= 2) begin
        mag   = (sum_copy < 0) ? 64'(-sum_copy) : 64'(sum_copy);
        num   = n * 64'(sq_sum_copy) - mag * mag;
        var64 = num / (n * (n - 1));
        st.stats_valid     = 1'b1;
        st.window_variance = var64[VAR_W-1:0];
        prod = 64'(st.window_variance) * 64'(ppy_copy);
        var64 = floor_sqrt(prod);
        st.annual_volatility = var64[VOL_W-1:0];
      end
    end
    expected_stats = {expected_stats, st};
  endtask

  // Driver: bursts of random length, random gaps between them.
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    sample_req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left  <= 8;
      gap_left    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_window('{op: in_ch.op, sample: in_ch.sample});
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          in_ch.valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs[0];
          pending_reqs.delete(0);
          in_ch.valid  <= 1'b1;
          in_ch.op     <= nxt.op;
          in_ch.sample <= nxt.sample;
          if (burst_left <= 1) begin
            // now and then a long burst with no gap at all
            burst_left <= ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 16);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern picked at random from three modes; one long hold-off to back up the input.
  int rx_cycle;
  int rx_mode;
  int hold_left;
  bit hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_cycle  <= 0;
      rx_mode   <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 63) rx_mode <= $urandom_range(0, 2);
      if (!hold_done && added_count >= 300) begin
        hold_done <= 1'b1;
        hold_left <= 3000;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    window_stats_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result count=%0d", $time, out_ch.sample_count);
        fail_count <= fail_count + 1;
      end else begin
        want = expected_stats[0];
        expected_stats.delete(0);
        if (out_ch.stats_valid !== want.stats_valid ||
            out_ch.sample_count !== want.sample_count ||
            out_ch.window_mean !== want.window_mean ||
            out_ch.window_variance !== want.window_variance ||
            out_ch.annual_volatility !== want.annual_volatility) begin
          $display("%0t: mismatch exp v=%0d n=%0d mean=%0d var=%0d vol=%0d", $time,
                   want.stats_valid, want.sample_count, want.window_mean,
                   want.window_variance, want.annual_volatility);
          $display("%0t:          got v=%0d n=%0d mean=%0d var=%0d vol=%0d", $time,
                   out_ch.stats_valid, out_ch.sample_count, out_ch.window_mean,
                   out_ch.window_variance, out_ch.annual_volatility);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  // Watchdog: cycles with nothing accepted on either channel.
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0, 1:    return SAMPLE_W'($urandom);
      2:       return SAMPLE_W'($urandom_range(0, 2047)) - SAMPLE_W'(1024);
      3:       return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      4:       return SAMPLE_W'($urandom_range(0, 65535)) - SAMPLE_W'(32768);
      default: return SAMPLE_W'($urandom_range(0, 15)) - SAMPLE_W'(8);
    endcase
  endfunction

  task automatic queue_add(input logic signed [SAMPLE_W-1:0] s);
    sample_req_t req;
    req = '{op: rwv_pkg::OP_ADD, sample: s};
    pending_reqs = {pending_reqs, req};
    added_count++;
  endtask

  task automatic queue_clear();
    sample_req_t req;
    req = '{op: rwv_pkg::OP_CLEAR, sample: SAMPLE_W'($urandom)};
    pending_reqs = {pending_reqs, req};
  endtask

  // mostly adds, a few clears
  task automatic queue_random(input int count);
    repeat (count) begin
      if ($urandom_range(0, 40) == 0) queue_clear();
      else queue_add(pick_sample());
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_stats.size() != 0);
    repeat (5) @(posedge clk);
  endtask

  // Register write; the predictor copy follows at the same edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rwv_pkg::REG_WINDOW_LENGTH) wl_copy = val[WL_W-1:0];
    else ppy_copy = val;
    @(posedge clk);
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.op     = rwv_pkg::OP_ADD;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    fail_count   = 0;
    added_count  = 0;
    ring_wr = 0; ring_held = 0; sum_copy = 0; sq_sum_copy = 0;
    wl_copy  = rwv_pkg::WL_RESET;
    ppy_copy = rwv_pkg::PPY_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, clear on empty, extremes, sign edges, long run of maxima.
    queue_clear();
    queue_add(24'sh7FFFFF);
    queue_add(24'sh800000);
    queue_add(24'sh000000);
    queue_add(-24'sd1);
    queue_add(24'sd1);
    queue_clear();
    queue_add(-24'sd3);
    queue_add(-24'sd4);
    repeat (8) queue_add(24'sh800000);
    repeat (8) queue_add(24'sh7FFFFF);
    wait_idle();

    // Shortest window, largest annualisation factor.
    write_reg(rwv_pkg::REG_WINDOW_LENGTH, 16'd2);
    write_reg(rwv_pkg::REG_PERIODS, 16'hFFFF);
    queue_clear();
    repeat (4) queue_add(24'sh800000);
    repeat (2) queue_add(24'sh7FFFFF);
    queue_random(200);
    wait_idle();

    // Below-range window length acts as two; zero periods gives zero volatility.
    write_reg(rwv_pkg::REG_WINDOW_LENGTH, 16'd0);
    write_reg(rwv_pkg::REG_PERIODS, 16'd0);
    queue_clear();
    queue_random(150);
    wait_idle();

    // Above-range window length acts as the full depth; smallest periods.
    write_reg(rwv_pkg::REG_WINDOW_LENGTH, 16'd100);
    write_reg(rwv_pkg::REG_PERIODS, 16'd1);
    queue_clear();
    queue_random(250);
    wait_idle();

    // Full window, then shorten it without a clear: count must stay put.
    write_reg(rwv_pkg::REG_WINDOW_LENGTH, 16'd64);
    write_reg(rwv_pkg::REG_PERIODS, 16'd252);
    queue_clear();
    queue_random(90);
    wait_idle();
    write_reg(rwv_pkg::REG_WINDOW_LENGTH, 16'd5);
    queue_random(120);
    wait_idle();

    // Mid-range settings, window length one.
    write_reg(rwv_pkg::REG_WINDOW_LENGTH, 16'd1);
    write_reg(rwv_pkg::REG_PERIODS, 16'd12);
    queue_clear();
    queue_random(120);
    wait_idle();
    write_reg(rwv_pkg::REG_WINDOW_LENGTH, 16'd17);
    write_reg(rwv_pkg::REG_PERIODS, 16'd365);
    queue_clear();
    queue_random(400);
    wait_idle();

    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_stats.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
